/* rtl/core/ipc_pkg.sv */
// Shared constants, codes and types of the interrupt priority controller.
// No dependencies; used by ipc_ctrl, ipc_datapath and the top level.
`default_nettype none

package ipc_pkg;

   // Source map
   localparam int SOURCE_COUNT   = 128;
   localparam int MASKABLE_FIRST = 4;
   localparam int MANAGED_BASE   = 4;
   localparam int SOFTWARE_FIRST = 64;

   localparam int SRC_W   = $clog2(SOURCE_COUNT);
   localparam int KIND_W  = 4;
   localparam int INDEX_W = 6;
   localparam int LEVEL_W = 2;
   localparam int REG_W   = 16;
   localparam int BIT_W   = $clog2(REG_W);
   // wide enough for every source number, base offset and software sum
   localparam int POS_W   = 8;

   // Priority search runs in groups of sixteen flags
   localparam int GROUP_W     = 16;
   localparam int OFFSET_W    = $clog2(GROUP_W);
   localparam int GROUP_COUNT = (SOURCE_COUNT + GROUP_W - 1) / GROUP_W;
   localparam int GROUP_IDX_W = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int PAD_W       = GROUP_COUNT * GROUP_W;

   localparam logic [SRC_W-1:0] SRC_RESET = SRC_W'(0);
   localparam logic [SRC_W-1:0] SRC_BREAK = SRC_W'(1);
   localparam logic [SRC_W-1:0] SRC_NMI   = SRC_W'(2);
   localparam logic [SRC_W-1:0] SRC_EMU   = SRC_W'(3);

   localparam logic [LEVEL_W-1:0] LEVEL_RESET    = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_NORMAL   = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_HIGH     = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_EMULATOR = 2'd3;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK          = 4'd0,
      KIND_RESET         = 4'd1,
      KIND_BREAK         = 4'd2,
      KIND_NMI           = 4'd3,
      KIND_EMULATOR      = 4'd4,
      KIND_MASKABLE      = 4'd5,
      KIND_SOFTWARE      = 4'd6,
      KIND_HALT          = 4'd7,
      KIND_STOP          = 4'd8,
      KIND_WRITE_MASK    = 4'd9,
      KIND_WRITE_PENDING = 4'd10,
      KIND_READ_MASK     = 4'd11,
      KIND_READ_PENDING  = 4'd12
   } kind_type;

   typedef enum logic [1:0] {
      MODE_RUN  = 2'd0,
      MODE_HALT = 2'd1,
      MODE_STOP = 2'd2
   } run_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic latch;
      logic scan;
      logic exec;
   } dp_cmd_type;

endpackage

`default_nettype wire

/* rtl/core/ipc_ctrl.sv */
// Sequencer of the interrupt priority controller: accept, scan, execute.
// Depends on ipc_pkg; drives the ipc_datapath command struct.
`default_nettype none

module ipc_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output ipc_pkg::dp_cmd_type     cmd
);

   ipc_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ipc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ipc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
            if (req_valid) begin
               state_in = ipc_pkg::ST_SCAN;
            end
         end
         ipc_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            state_in = ipc_pkg::ST_EXEC;
         end
         ipc_pkg::ST_EXEC: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.exec = 1'b1;
               state_in = ipc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ipc_pkg::ST_IDLE;
         end
      endcase

      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_to_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ipc_pkg::ST_SCAN))
      else $error("accepted beat did not enter the scan step");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.exec))
      else $error("result became valid without an execute step");

   a_stall_holds_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ipc_pkg::ST_EXEC && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == ipc_pkg::ST_EXEC))
      else $error("execute step left while the result register was full");
`endif

endmodule

`default_nettype wire

/* rtl/core/ipc_datapath.sv */
// Datapath of the interrupt priority controller: source flags, mask, pending,
// run mode, grouped priority search and the result register. Depends on ipc_pkg.
`default_nettype none

module ipc_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire ipc_pkg::dp_cmd_type              cmd,
   input  wire logic [ipc_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [ipc_pkg::INDEX_W-1:0]      req_irq_index,
   input  wire logic [ipc_pkg::LEVEL_W-1:0]      req_cpu_level,
   input  wire logic                             req_master_enable,
   input  wire logic [ipc_pkg::REG_W-1:0]        req_write_data,
   output logic                                  rsp_accepted,
   output logic [ipc_pkg::SRC_W-1:0]             rsp_accept_index,
   output logic [ipc_pkg::LEVEL_W-1:0]           rsp_accept_level,
   output logic                                  rsp_raise_cpu,
   output logic                                  rsp_chip_reset,
   output logic                                  rsp_cpu_step,
   output logic [ipc_pkg::REG_W-1:0]             rsp_read_data,
   output logic                                  rsp_level_error
);

   localparam int GC  = ipc_pkg::GROUP_COUNT;
   localparam int GW  = ipc_pkg::GROUP_W;
   localparam int OW  = ipc_pkg::OFFSET_W;
   localparam int GIW = ipc_pkg::GROUP_IDX_W;
   localparam int PW  = ipc_pkg::POS_W;
   localparam int SW  = ipc_pkg::SRC_W;

   // Latched beat
   logic [ipc_pkg::KIND_W-1:0]  kind_ff;
   logic [ipc_pkg::INDEX_W-1:0] index_ff;
   logic [ipc_pkg::LEVEL_W-1:0] level_ff;
   logic                        enable_ff;
   logic [ipc_pkg::REG_W-1:0]   data_ff;

   // Architectural state
   logic [ipc_pkg::SOURCE_COUNT-1:0] active_ff, active_in;
   logic [ipc_pkg::REG_W-1:0]        mask_ff, mask_in;
   logic [ipc_pkg::REG_W-1:0]        pend_ff, pend_in;
   ipc_pkg::run_mode_type            mode_ff, mode_in;

   // First search stage, one entry per group
   logic [GC-1:0]         sw_any_ff, sw_any_in;
   logic [GC-1:0]         mk_any_ff, mk_any_in;
   logic [GC-1:0][OW-1:0] sw_off_ff, sw_off_in;
   logic [GC-1:0][OW-1:0] mk_off_ff, mk_off_in;

   logic [ipc_pkg::PAD_W-1:0] active_pad, sw_vec, mk_vec;
   logic [GW-1:0]             grp_bits, grp_low;

   // Second search stage
   logic [GC-1:0]       sw_gsel, mk_gsel;
   logic [GIW-1:0]      sw_gidx, mk_gidx;
   logic [GIW+OW-1:0]   sw_pos, mk_pos;
   logic [SW-1:0]       sw_idx, mk_idx;
   logic                sw_found, mk_found;

   // Execute step
   logic                        found, maskable, deliver, level_err;
   logic [SW-1:0]               sel;
   logic [ipc_pkg::LEVEL_W-1:0] lvl;
   logic [PW-1:0]               bit_diff, soft_num;
   logic                        bit_ok;
   logic [ipc_pkg::BIT_W-1:0]   bit_pos;
   logic                        chip_rst, step;
   logic [ipc_pkg::REG_W-1:0]   rd_data;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff   <= req_kind;
         index_ff  <= req_irq_index;
         level_ff  <= req_cpu_level;
         enable_ff <= req_master_enable;
         data_ff   <= req_write_data;
      end
   end

   // Group search: isolate the lowest set flag of each group, then encode
   always_comb begin
      active_pad = ipc_pkg::PAD_W'(active_ff);
      for (int i = 0; i < ipc_pkg::PAD_W; i++) begin
         sw_vec[i] = active_pad[i] && (i >= ipc_pkg::SOFTWARE_FIRST)
                     && (i < ipc_pkg::SOURCE_COUNT);
         mk_vec[i] = active_pad[i] && (i >= ipc_pkg::MASKABLE_FIRST)
                     && (i < ipc_pkg::SOFTWARE_FIRST) && (i < ipc_pkg::SOURCE_COUNT);
      end
      sw_any_in = '0;
      mk_any_in = '0;
      sw_off_in = '0;
      mk_off_in = '0;
      grp_bits  = '0;
      grp_low   = '0;
      for (int g = 0; g < GC; g++) begin
         grp_bits     = sw_vec[g*GW +: GW];
         grp_low      = grp_bits & (~grp_bits + GW'(1));
         sw_any_in[g] = |grp_bits;
         for (int b = 0; b < GW; b++) begin
            if (grp_low[b]) sw_off_in[g] = sw_off_in[g] | OW'(b);
         end
         grp_bits     = mk_vec[g*GW +: GW];
         grp_low      = grp_bits & (~grp_bits + GW'(1));
         mk_any_in[g] = |grp_bits;
         for (int b = 0; b < GW; b++) begin
            if (grp_low[b]) mk_off_in[g] = mk_off_in[g] | OW'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         sw_any_ff <= sw_any_in;
         mk_any_ff <= mk_any_in;
         sw_off_ff <= sw_off_in;
         mk_off_ff <= mk_off_in;
      end
   end

   // Lowest group with a hit
   always_comb begin
      sw_gsel = sw_any_ff & (~sw_any_ff + GC'(1));
      mk_gsel = mk_any_ff & (~mk_any_ff + GC'(1));
      sw_gidx = '0;
      mk_gidx = '0;
      for (int g = 0; g < GC; g++) begin
         if (sw_gsel[g]) sw_gidx = sw_gidx | GIW'(g);
         if (mk_gsel[g]) mk_gidx = mk_gidx | GIW'(g);
      end
      sw_found = |sw_any_ff;
      mk_found = |mk_any_ff;
      sw_pos   = {sw_gidx, sw_off_ff[sw_gidx]};
      mk_pos   = {mk_gidx, mk_off_ff[mk_gidx]};
      sw_idx   = SW'(sw_pos);
      mk_idx   = SW'(mk_pos);
   end

   // Execute the latched beat
   always_comb begin
      active_in = active_ff;
      mask_in   = mask_ff;
      pend_in   = pend_ff;
      mode_in   = mode_ff;
      found     = 1'b0;
      maskable  = 1'b0;
      deliver   = 1'b0;
      level_err = 1'b0;
      sel       = '0;
      lvl       = '0;
      chip_rst  = 1'b0;
      step      = 1'b0;
      rd_data   = '0;
      bit_diff  = PW'(mk_idx) - PW'(ipc_pkg::MANAGED_BASE);
      bit_ok    = (PW'(mk_idx) >= PW'(ipc_pkg::MANAGED_BASE))
                  && (bit_diff < PW'(ipc_pkg::REG_W));
      bit_pos   = bit_diff[ipc_pkg::BIT_W-1:0];
      soft_num  = PW'(ipc_pkg::SOFTWARE_FIRST) + PW'(index_ff);

      if (cmd.exec) begin
         unique case (ipc_pkg::kind_type'(kind_ff))
            ipc_pkg::KIND_TICK: begin
               found = 1'b1;
               priority if (active_ff[ipc_pkg::SRC_RESET]) begin
                  sel = ipc_pkg::SRC_RESET;
                  lvl = ipc_pkg::LEVEL_RESET;
               end else if (sw_found) begin
                  sel       = sw_idx;
                  lvl       = ipc_pkg::LEVEL_NORMAL;
                  level_err = (level_ff > 2'd1);
               end else if (active_ff[ipc_pkg::SRC_EMU]) begin
                  sel = ipc_pkg::SRC_EMU;
                  lvl = ipc_pkg::LEVEL_EMULATOR;
               end else if (active_ff[ipc_pkg::SRC_BREAK]) begin
                  sel = ipc_pkg::SRC_BREAK;
                  lvl = ipc_pkg::LEVEL_HIGH;
               end else if (active_ff[ipc_pkg::SRC_NMI] && level_ff <= 2'd2) begin
                  sel = ipc_pkg::SRC_NMI;
                  lvl = ipc_pkg::LEVEL_HIGH;
               end else if (mk_found && level_ff <= 2'd1) begin
                  sel      = mk_idx;
                  lvl      = ipc_pkg::LEVEL_NORMAL;
                  maskable = 1'b1;
               end else begin
                  found = 1'b0;
               end
               deliver = found;
               if (maskable) begin
                  deliver = 1'b0;
                  if (bit_ok && mask_ff[bit_pos]) begin
                     pend_in[bit_pos] = 1'b1;
                     deliver          = enable_ff;
                  end
               end
               if (found) begin
                  active_in[sel] = 1'b0;
                  mode_in        = ipc_pkg::MODE_RUN;
               end
               step = found || (mode_ff == ipc_pkg::MODE_RUN);
            end
            ipc_pkg::KIND_RESET: begin
               chip_rst = 1'b1;
            end
            ipc_pkg::KIND_BREAK: begin
               if (level_ff > 2'd1) begin
                  chip_rst = 1'b1;
               end else begin
                  active_in[ipc_pkg::SRC_BREAK] = 1'b1;
               end
            end
            ipc_pkg::KIND_NMI: begin
               active_in[ipc_pkg::SRC_NMI] = 1'b1;
            end
            ipc_pkg::KIND_EMULATOR: begin
               active_in[ipc_pkg::SRC_EMU] = 1'b1;
            end
            ipc_pkg::KIND_MASKABLE: begin
               // drop raises outside the maskable range
               if (PW'(index_ff) >= PW'(ipc_pkg::MASKABLE_FIRST)
                   && PW'(index_ff) < PW'(ipc_pkg::SOFTWARE_FIRST)
                   && PW'(index_ff) < PW'(ipc_pkg::SOURCE_COUNT)) begin
                  active_in[SW'(index_ff)] = 1'b1;
               end
            end
            ipc_pkg::KIND_SOFTWARE: begin
               if (soft_num < PW'(ipc_pkg::SOURCE_COUNT)) begin
                  active_in[SW'(soft_num)] = 1'b1;
               end
            end
            ipc_pkg::KIND_HALT: begin
               mode_in = ipc_pkg::MODE_HALT;
            end
            ipc_pkg::KIND_STOP: begin
               mode_in = ipc_pkg::MODE_STOP;
            end
            ipc_pkg::KIND_WRITE_MASK: begin
               mask_in = data_ff;
            end
            ipc_pkg::KIND_WRITE_PENDING: begin
               pend_in = data_ff;
            end
            ipc_pkg::KIND_READ_MASK: begin
               rd_data = mask_ff;
            end
            ipc_pkg::KIND_READ_PENDING: begin
               rd_data = pend_ff;
            end
            default: begin
            end
         endcase

         if (chip_rst) begin
            active_in                     = '0;
            active_in[ipc_pkg::SRC_RESET] = 1'b1;
            mask_in                       = '0;
            pend_in                       = '0;
            mode_in                       = ipc_pkg::MODE_RUN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff                     <= '0;
         active_ff[ipc_pkg::SRC_RESET] <= 1'b1;
         mask_ff                       <= '0;
         pend_ff                       <= '0;
         mode_ff                       <= ipc_pkg::MODE_RUN;
      end else begin
         active_ff <= active_in;
         mask_ff   <= mask_in;
         pend_ff   <= pend_in;
         mode_ff   <= mode_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_accepted     <= found;
         rsp_accept_index <= found ? sel : '0;
         rsp_accept_level <= found ? lvl : '0;
         rsp_raise_cpu    <= deliver;
         rsp_chip_reset   <= chip_rst;
         rsp_cpu_step     <= step;
         rsp_read_data    <= rd_data;
         rsp_level_error  <= level_err;
      end
   end

`ifndef SYNTHESIS
   a_reset_restores: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && kind_ff == ipc_pkg::KIND_RESET)
      |=> (active_ff[ipc_pkg::SRC_RESET] && mask_ff == '0 && pend_ff == '0))
      else $error("reset beat did not restore the reset state");

   a_flags_need_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> ((!rsp_level_error && !rsp_raise_cpu) || rsp_accepted))
      else $error("delivery or level error reported without an accepted source");

   a_idle_tick_keeps: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && kind_ff == ipc_pkg::KIND_TICK)
      |=> (rsp_accepted || active_ff == $past(active_ff)))
      else $error("tick without acceptance changed the source flags");
`endif

endmodule

`default_nettype wire

/* rtl/core/interrupt_priority_controller.sv */
// Top level of the interrupt priority controller.
// Depends on ipc_pkg, ipc_ctrl and ipc_datapath.
`default_nettype none

// Interrupt acceptance unit. Each request beat raises a source, changes the
// run mode, reads or writes the 16-bit mask and pending registers, or ticks;
// every beat returns exactly one response beat. A tick accepts at most one
// active source by fixed priority: reset, lowest software source, emulator,
// break, nonmaskable (CPU level at most 2), lowest maskable source (CPU level
// at most 1), and reports its number, level and whether it reaches the CPU.
// A reset beat, or a break beat at CPU level above 1, resets the whole unit
// and sets chip_reset in its response. Each beat passes through the accept,
// group search and execute steps before its response becomes valid, and the
// next beat is taken only after the previous one leaves its execute step. The
// steps follow from the two-step priority search over the 128 source flags:
// the first step finds the lowest flag in each group of sixteen and
// registers it, the second picks the lowest group and updates the state. A
// new beat is taken while the previous response still waits in the output
// register; a stalled response holds the next beat in its execute step.
module interrupt_priority_controller (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ipc_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [ipc_pkg::INDEX_W-1:0]   req_irq_index,
   input  wire logic [ipc_pkg::LEVEL_W-1:0]   req_cpu_level,
   input  wire logic                          req_master_enable,
   input  wire logic [ipc_pkg::REG_W-1:0]     req_write_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_accepted,
   output logic [ipc_pkg::SRC_W-1:0]          rsp_accept_index,
   output logic [ipc_pkg::LEVEL_W-1:0]        rsp_accept_level,
   output logic                               rsp_raise_cpu,
   output logic                               rsp_chip_reset,
   output logic                               rsp_cpu_step,
   output logic [ipc_pkg::REG_W-1:0]          rsp_read_data,
   output logic                               rsp_level_error
);

   // Commands from the sequencer: latch the beat, run the group search,
   // execute and load the response register.
   ipc_pkg::dp_cmd_type cmd;

   ipc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Flags, registers, run mode, priority search and response fields
   ipc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_kind          (req_kind),
      .req_irq_index     (req_irq_index),
      .req_cpu_level     (req_cpu_level),
      .req_master_enable (req_master_enable),
      .req_write_data    (req_write_data),
      .rsp_accepted      (rsp_accepted),
      .rsp_accept_index  (rsp_accept_index),
      .rsp_accept_level  (rsp_accept_level),
      .rsp_raise_cpu     (rsp_raise_cpu),
      .rsp_chip_reset    (rsp_chip_reset),
      .rsp_cpu_step      (rsp_cpu_step),
      .rsp_read_data     (rsp_read_data),
      .rsp_level_error   (rsp_level_error)
   );

endmodule

`default_nettype wire

/* tb/ipc_checker.sv */
// Checker for the interrupt priority controller: snoops both channels,
// predicts one response beat per request beat and compares field by field.
// Depends on ipc_pkg for widths, source numbers, levels, kinds and run modes.

module ipc_checker
   import ipc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic [KIND_W-1:0]  req_kind,
   input  wire logic [INDEX_W-1:0] req_irq_index,
   input  wire logic [LEVEL_W-1:0] req_cpu_level,
   input  wire logic               req_master_enable,
   input  wire logic [REG_W-1:0]   req_write_data,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic               rsp_accepted,
   input  wire logic [SRC_W-1:0]   rsp_accept_index,
   input  wire logic [LEVEL_W-1:0] rsp_accept_level,
   input  wire logic               rsp_raise_cpu,
   input  wire logic               rsp_chip_reset,
   input  wire logic               rsp_cpu_step,
   input  wire logic [REG_W-1:0]   rsp_read_data,
   input  wire logic               rsp_level_error,
   output int                      mismatch_count,
   output int                      awaited_count
);

   typedef struct packed {
      logic               accepted;
      logic [SRC_W-1:0]   index;
      logic [LEVEL_W-1:0] level;
      logic               raise_cpu;
      logic               chip_reset;
      logic               cpu_step;
      logic [REG_W-1:0]   read_data;
      logic               level_error;
   } irq_outcome_type;

   bit              src_flag [SOURCE_COUNT];
   logic [REG_W-1:0] mask_q;
   logic [REG_W-1:0] pending_q;
   run_mode_type    mode_q;
   irq_outcome_type outcome_q [$];
   irq_outcome_type want;

   function automatic void clear_controller();
      foreach (src_flag[n]) src_flag[n] = 1'b0;
      src_flag[SRC_RESET] = 1'b1;
      mask_q    = '0;
      pending_q = '0;
      mode_q    = MODE_RUN;
   endfunction

   // Advance the shadow state by one request beat and return its response.
   function automatic irq_outcome_type predict_outcome(
      logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] idx, logic [LEVEL_W-1:0] lvl,
      logic en, logic [REG_W-1:0] wdata);
      irq_outcome_type o;
      bit              found;
      int              sel;
      int              bitpos;
      o     = '0;
      found = 1'b0;
      sel   = 0;
      case (kind_type'(kind))
         KIND_TICK: begin
            if (src_flag[SRC_RESET]) begin
               found = 1'b1;
               sel   = SRC_RESET;
            end
            for (int n = SOFTWARE_FIRST; n < SOURCE_COUNT; n++)
               if (!found && src_flag[n]) begin
                  found = 1'b1;
                  sel   = n;
               end
            if (!found && src_flag[SRC_EMU]) begin
               found = 1'b1;
               sel   = SRC_EMU;
            end
            if (!found && src_flag[SRC_BREAK]) begin
               found = 1'b1;
               sel   = SRC_BREAK;
            end
            if (!found && src_flag[SRC_NMI] && lvl <= LEVEL_HIGH) begin
               found = 1'b1;
               sel   = SRC_NMI;
            end
            if (!found && lvl <= LEVEL_NORMAL)
               for (int n = MASKABLE_FIRST; n < SOFTWARE_FIRST && n < SOURCE_COUNT; n++)
                  if (!found && src_flag[n]) begin
                     found = 1'b1;
                     sel   = n;
                  end
            if (found) begin
               o.accepted  = 1'b1;
               o.index     = SRC_W'(sel);
               o.raise_cpu = 1'b1;
               if (sel == SRC_RESET)
                  o.level = LEVEL_RESET;
               else if (sel == SRC_BREAK || sel == SRC_NMI)
                  o.level = LEVEL_HIGH;
               else if (sel == SRC_EMU)
                  o.level = LEVEL_EMULATOR;
               else
                  o.level = LEVEL_NORMAL;
               // maskable: delivered only with mask bit and master enable
               if (sel >= MASKABLE_FIRST && sel < SOFTWARE_FIRST) begin
                  o.raise_cpu = 1'b0;
                  bitpos = sel - MANAGED_BASE;
                  if (bitpos >= 0 && bitpos < REG_W && mask_q[bitpos]) begin
                     pending_q[bitpos] = 1'b1;
                     o.raise_cpu = en;
                  end
               end
               o.level_error = (sel >= SOFTWARE_FIRST) && (lvl > LEVEL_NORMAL);
               src_flag[sel] = 1'b0;
               mode_q = MODE_RUN;
            end
            o.cpu_step = (mode_q == MODE_RUN);
         end
         KIND_RESET: begin
            clear_controller();
            o.chip_reset = 1'b1;
         end
         KIND_BREAK: begin
            if (lvl > LEVEL_NORMAL) begin
               clear_controller();
               o.chip_reset = 1'b1;
            end else begin
               src_flag[SRC_BREAK] = 1'b1;
            end
         end
         KIND_NMI:      src_flag[SRC_NMI] = 1'b1;
         KIND_EMULATOR: src_flag[SRC_EMU] = 1'b1;
         KIND_MASKABLE: begin
            if (idx >= MASKABLE_FIRST && idx < SOFTWARE_FIRST && idx < SOURCE_COUNT)
               src_flag[idx] = 1'b1;
         end
         KIND_SOFTWARE: begin
            if (SOFTWARE_FIRST + idx < SOURCE_COUNT)
               src_flag[SOFTWARE_FIRST + idx] = 1'b1;
         end
         KIND_HALT:          mode_q = MODE_HALT;
         KIND_STOP:          mode_q = MODE_STOP;
         KIND_WRITE_MASK:    mask_q = wdata;
         KIND_WRITE_PENDING: pending_q = wdata;
         KIND_READ_MASK:     o.read_data = mask_q;
         KIND_READ_PENDING:  o.read_data = pending_q;
         default: ;
      endcase
      return o;
   endfunction

   function automatic void check_field(string name, logic [REG_W-1:0] exp_val,
                                       logic [REG_W-1:0] act_val);
      if (act_val !== exp_val) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h actual %0h",
                  $time, name, exp_val, act_val);
      end
   endfunction

   initial begin
      mismatch_count = 0;
      awaited_count  = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_controller();
         outcome_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: response beat with nothing expected, expected none actual %0h",
                        $time, rsp_accept_index);
            end else begin
               want = outcome_q.pop_front();
               check_field("accepted",     REG_W'(want.accepted),    REG_W'(rsp_accepted));
               check_field("accept_index", REG_W'(want.index),       REG_W'(rsp_accept_index));
               check_field("accept_level", REG_W'(want.level),       REG_W'(rsp_accept_level));
               check_field("raise_cpu",    REG_W'(want.raise_cpu),   REG_W'(rsp_raise_cpu));
               check_field("chip_reset",   REG_W'(want.chip_reset),  REG_W'(rsp_chip_reset));
               check_field("cpu_step",     REG_W'(want.cpu_step),    REG_W'(rsp_cpu_step));
               check_field("read_data",    want.read_data,           rsp_read_data);
               check_field("level_error",  REG_W'(want.level_error), REG_W'(rsp_level_error));
            end
         end
         if (req_valid && req_ready)
            outcome_q.push_back(predict_outcome(req_kind, req_irq_index, req_cpu_level,
                                                req_master_enable, req_write_data));
      end
      awaited_count = outcome_q.size();
   end

endmodule

/* tb/tb_top.sv */
// Top of the interrupt priority controller testbench: clock, reset, request
// stimulus, response back-pressure and the verdict.
// Depends on ipc_pkg, interrupt_priority_controller and ipc_checker.

module tb_top;
   import ipc_pkg::*;

   localparam int RANDOM_BEATS = 1600;
   localparam int CYCLE_LIMIT  = 600000;
   // time after the drain for spurious response beats to show up
   localparam int DRAIN_CYCLES = 12;
   // kinds past the last defined code; the block must treat them as no-ops
   localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 4'd13;
   localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 4'd15;
   localparam logic [REG_W-1:0]  ALL_ONES         = 16'hFFFF;

   logic               clock;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_ready;
   logic [KIND_W-1:0]  req_kind          = '0;
   logic [INDEX_W-1:0] req_irq_index     = '0;
   logic [LEVEL_W-1:0] req_cpu_level     = '0;
   logic               req_master_enable = 1'b0;
   logic [REG_W-1:0]   req_write_data    = '0;
   logic               rsp_valid;
   logic               rsp_ready         = 1'b0;
   logic               rsp_accepted;
   logic [SRC_W-1:0]   rsp_accept_index;
   logic [LEVEL_W-1:0] rsp_accept_level;
   logic               rsp_raise_cpu;
   logic               rsp_chip_reset;
   logic               rsp_cpu_step;
   logic [REG_W-1:0]   rsp_read_data;
   logic               rsp_level_error;

   int mismatch_count;
   int awaited_count;
   int cycle_count = 0;
   // set during stretches where the request side never idles
   bit gap_free    = 1'b0;

   interrupt_priority_controller dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_irq_index     (req_irq_index),
      .req_cpu_level     (req_cpu_level),
      .req_master_enable (req_master_enable),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted      (rsp_accepted),
      .rsp_accept_index  (rsp_accept_index),
      .rsp_accept_level  (rsp_accept_level),
      .rsp_raise_cpu     (rsp_raise_cpu),
      .rsp_chip_reset    (rsp_chip_reset),
      .rsp_cpu_step      (rsp_cpu_step),
      .rsp_read_data     (rsp_read_data),
      .rsp_level_error   (rsp_level_error)
   );

   ipc_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_irq_index     (req_irq_index),
      .req_cpu_level     (req_cpu_level),
      .req_master_enable (req_master_enable),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted      (rsp_accepted),
      .rsp_accept_index  (rsp_accept_index),
      .rsp_accept_level  (rsp_accept_level),
      .rsp_raise_cpu     (rsp_raise_cpu),
      .rsp_chip_reset    (rsp_chip_reset),
      .rsp_cpu_step      (rsp_cpu_step),
      .rsp_read_data     (rsp_read_data),
      .rsp_level_error   (rsp_level_error),
      .mismatch_count    (mismatch_count),
      .awaited_count     (awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one; none inside a gap-free stretch.
   function automatic int pick_gap(bit no_idle);
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // Drive one request beat at the current edge and hold it until taken.
   // On return the beat was accepted at the edge just passed, so the caller
   // may drive the next beat (or drop valid) in this very time step.
   task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] idx,
                            input logic [LEVEL_W-1:0] lvl, input logic en,
                            input logic [REG_W-1:0] data);
      int gap;
      gap = pick_gap(gap_free);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_irq_index     <= idx;
      req_cpu_level     <= lvl;
      req_master_enable <= en;
      req_write_data    <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Response back-pressure: stalls of random length, plus long stretches
   // with ready held high so the block also runs at full rate.
   initial begin : rsp_side
      int roll;
      int stall;
      @(posedge clock);
      forever begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            rsp_ready <= 1'b1;
            repeat (120) @(posedge clock);
         end else begin
            stall = pick_gap(1'b0);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int                 roll;
      logic [KIND_W-1:0]  kind;
      logic [INDEX_W-1:0] idx;
      logic [LEVEL_W-1:0] lvl;
      logic               en;
      logic [REG_W-1:0]   data;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // reset source is live out of reset; the pending register reads back zero
      send_beat(KIND_READ_PENDING, 6'd0, 2'd0, 1'b0, 16'h0000);
      send_beat(KIND_TICK,         6'd0, 2'd3, 1'b0, 16'h0000);
      // halt, then a tick with nothing eligible must leave the unit halted
      send_beat(KIND_HALT,         6'd0, 2'd0, 1'b0, 16'h0000);
      send_beat(KIND_TICK,         6'd0, 2'd0, 1'b1, 16'h0000);
      send_beat(KIND_WRITE_MASK,   6'd0, 2'd0, 1'b0, ALL_ONES);
      // lowest and highest managed bit, one past the register, the top
      // maskable number, one below the maskable range, and a repeat raise
      send_beat(KIND_MASKABLE,     6'd4,  2'd0, 1'b0, 16'h0000);
      send_beat(KIND_MASKABLE,     6'd19, 2'd0, 1'b0, 16'h0000);
      send_beat(KIND_MASKABLE,     6'd20, 2'd0, 1'b0, 16'h0000);
      send_beat(KIND_MASKABLE,     6'd63, 2'd0, 1'b0, 16'h0000);
      send_beat(KIND_MASKABLE,     6'd3,  2'd0, 1'b0, 16'h0000);
      send_beat(KIND_MASKABLE,     6'd4,  2'd0, 1'b0, 16'h0000);
      // level 2 blocks maskables; then deliver, then accept with enable low
      send_beat(KIND_TICK,         6'd0, 2'd2, 1'b1, 16'h0000);
      send_beat(KIND_TICK,         6'd0, 2'd1, 1'b1, 16'h0000);
      send_beat(KIND_TICK,         6'd0, 2'd0, 1'b0, 16'h0000);
      // stop mode is cleared by an acceptance; source 20 goes in silently
      send_beat(KIND_STOP,         6'd0, 2'd0, 1'b0, 16'h0000);
      send_beat(KIND_TICK,         6'd0, 2'd1, 1'b1, 16'h0000);
      // full priority ladder: software beats emulator beats break beats nmi
      send_beat(KIND_SOFTWARE,     6'd63, 2'd0, 1'b0, 16'h0000);
      send_beat(KIND_SOFTWARE,     6'd0,  2'd0, 1'b0, 16'h0000);
      send_beat(KIND_EMULATOR,     6'd0,  2'd0, 1'b0, 16'h0000);
      send_beat(KIND_BREAK,        6'd0,  2'd1, 1'b0, 16'h0000);
      send_beat(KIND_NMI,          6'd0,  2'd0, 1'b0, 16'h0000);
      // software at a high level raises the level error
      send_beat(KIND_TICK,         6'd0, 2'd3, 1'b1, 16'h0000);
      send_beat(KIND_TICK,         6'd0, 2'd0, 1'b1, 16'h0000);
      send_beat(KIND_TICK,         6'd0, 2'd3, 1'b1, 16'h0000);
      send_beat(KIND_TICK,         6'd0, 2'd3, 1'b1, 16'h0000);
      // level 3 holds off nmi and maskable alike
      send_beat(KIND_TICK,         6'd0, 2'd3, 1'b1, 16'h0000);
      send_beat(KIND_TICK,         6'd0, 2'd2, 1'b1, 16'h0000);
      send_beat(KIND_READ_PENDING, 6'd0, 2'd0, 1'b0, 16'h0000);
      send_beat(KIND_WRITE_PENDING, 6'd0, 2'd0, 1'b0, 16'h5A5A);
      send_beat(KIND_SPARE_LAST,   6'd63, 2'd3, 1'b1, ALL_ONES);
      // break above level 1 turns into a chip reset
      send_beat(KIND_BREAK,        6'd0, 2'd2, 1'b0, 16'h0000);
      send_beat(KIND_READ_MASK,    6'd0, 2'd0, 1'b0, 16'h0000);

      // ---- random part ----
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         gap_free = ((i / 200) % 4) == 3;
         roll = $urandom_range(0, 99);
         idx  = INDEX_W'($urandom_range(0, 63));
         // bias toward low levels so maskables and nmi get through often
         lvl  = ($urandom_range(0, 3) == 0) ? LEVEL_W'($urandom_range(2, 3))
                                            : LEVEL_W'($urandom_range(0, 1));
         en   = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 7))
            0:       data = '0;
            1:       data = ALL_ONES;
            default: data = REG_W'($urandom_range(0, 65535));
         endcase
         if (roll < 30)
            kind = KIND_TICK;
         else if (roll < 50) begin
            kind = KIND_MASKABLE;
            // mostly sources around the managed window, sometimes anywhere
            if ($urandom_range(0, 9) < 7)
               idx = INDEX_W'($urandom_range(MASKABLE_FIRST, MANAGED_BASE + REG_W + 1));
         end else if (roll < 58) begin
            kind = KIND_SOFTWARE;
            if ($urandom_range(0, 3) != 0)
               idx = INDEX_W'($urandom_range(0, 7));
         end
         else if (roll < 62) kind = KIND_EMULATOR;
         else if (roll < 66) kind = KIND_NMI;
         else if (roll < 69) kind = KIND_BREAK;
         else if (roll < 70) kind = KIND_RESET;
         else if (roll < 74) kind = KIND_HALT;
         else if (roll < 77) kind = KIND_STOP;
         else if (roll < 83) kind = KIND_WRITE_MASK;
         else if (roll < 87) kind = KIND_WRITE_PENDING;
         else if (roll < 92) kind = KIND_READ_MASK;
         else if (roll < 97) kind = KIND_READ_PENDING;
         else kind = KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
         send_beat(kind, idx, lvl, en, data);
      end

      // drop valid, drain outstanding responses, then hold a few more cycles
      req_valid <= 1'b0;
      @(posedge clock);
      wait (awaited_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/ipc_pkg.sv
rtl/core/ipc_ctrl.sv
rtl/core/ipc_datapath.sv
rtl/core/interrupt_priority_controller.sv
tb/ipc_checker.sv
tb/tb_top.sv
